[hw/rtl/mtf_pkg.sv]
// Shared types and constants for the move-to-front coder.
// Used by mtf_cell, mtf_reduce and move_to_front_transform; no dependencies.
`default_nettype none

package mtf_pkg;

  // List geometry: one cell per byte value
  localparam int SYM_W      = 8;
  localparam int LIST_SIZE  = 1 << SYM_W;
  localparam int GRP_W      = 4;
  localparam int GROUP_SIZE = 1 << GRP_W;
  localparam int NUM_GROUPS = LIST_SIZE / GROUP_SIZE;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [GRP_W-1:0] sub_t;
  typedef logic [SYM_W-GRP_W-1:0] grp_t;

  // Input and result items
  typedef struct packed {
    sym_t value_in;
    logic last_in_block;
  } in_item_t;

  typedef struct packed {
    sym_t value_out;
    logic last_of_block;
  } out_item_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic capture;  // compare the incoming value and register the hit flag
    logic decode;   // hit on list position instead of on stored symbol
    logic shift;    // move the chosen symbol to the front
    sym_t value;    // incoming symbol or position
    sym_t pos;      // position of the chosen symbol
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/mtf_cell.sv]
// One list entry of the move-to-front chain: holds a symbol and a hit flag.
// Depends on mtf_pkg.
`default_nettype none

module mtf_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mtf_pkg::sym_t      idx,
  input  wire mtf_pkg::cell_ctrl_t ctrl,
  input  wire mtf_pkg::sym_t      prev_sym,
  output mtf_pkg::sym_t           sym,
  output logic                    hit
);
  import mtf_pkg::*;

  // Compare on capture; take the neighbor's symbol when at or ahead of the chosen position
  always_ff @(posedge clk) begin
    if (rst) begin
      sym <= idx;
      hit <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        hit <= ctrl.decode ? (idx == ctrl.value) : (sym == ctrl.value);
      end
      if (ctrl.shift && (idx <= ctrl.pos)) begin
        sym <= prev_sym;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mtf_reduce.sv]
// Registered two-level OR tree that turns the one-hot hit row into the
// chosen position and its symbol. Depends on mtf_pkg.
`default_nettype none

module mtf_reduce (
  input  wire logic                                  clk,
  input  wire logic [mtf_pkg::LIST_SIZE-1:0]         hit,
  input  wire mtf_pkg::sym_t [mtf_pkg::LIST_SIZE-1:0] list,
  output mtf_pkg::sym_t                              pos,
  output mtf_pkg::sym_t                              sym
);
  import mtf_pkg::*;

  logic [NUM_GROUPS-1:0] grp_hit_c, grp_hit;
  sub_t [NUM_GROUPS-1:0] grp_low_c, grp_low;
  sym_t [NUM_GROUPS-1:0] grp_sym_c, grp_sym;

  // First level: collapse each group of cells
  always_comb begin
    grp_hit_c = '0;
    grp_low_c = '0;
    grp_sym_c = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (hit[g*GROUP_SIZE + j]) begin
          grp_hit_c[g] = 1'b1;
          grp_low_c[g] = grp_low_c[g] | sub_t'(j);
          grp_sym_c[g] = grp_sym_c[g] | list[g*GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit <= grp_hit_c;
    grp_low <= grp_low_c;
    grp_sym <= grp_sym_c;
  end

  // Second level: combine the group results
  always_comb begin
    pos = '0;
    sym = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp_hit[g]) begin
        pos = pos | {grp_t'(g), grp_low[g]};
        sym = sym | grp_sym[g];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/move_to_front_transform.sv]
// Move-to-front coder over a 256-entry byte list built as a chain of cells.
// Items are taken one at a time, each through these steps in order: compare
// in all cells, registered group stage of the position/symbol reduction,
// then the shift along the chain, held while the result channel stalls.
// Reset: list returns to identity order, direction to encode, channels empty.
// Depends on mtf_pkg, mtf_cell and mtf_reduce.
`default_nettype none

module move_to_front_transform (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mtf_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mtf_pkg::out_item_t     out_data
);
  import mtf_pkg::*;

  state_t     state, state_next;
  logic       direction;
  logic       last_q;
  logic       accept;
  logic       advance;
  cell_ctrl_t ctrl;
  sym_t       red_pos, red_sym;

  logic [LIST_SIZE-1:0] hit;
  sym_t [LIST_SIZE-1:0] list;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (advance) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.shift   = 1'b0;
    ctrl.decode  = direction;
    ctrl.value   = in_data.value_in;
    ctrl.pos     = red_pos;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      ST_REDUCE: begin
      end
      ST_SHIFT: begin
        ctrl.shift = advance;
      end
      default: begin
      end
    endcase
  end

  assign accept      = in_valid && in_ready;
  assign advance     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the pass-through flag
  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= in_data.last_in_block;
    end
  end

  // Chain of cells; the front cell takes the chosen symbol
  for (genvar k = 0; k < LIST_SIZE; k++) begin : g_cell
    sym_t prev_sym;
    if (k == 0) begin : g_front
      assign prev_sym = red_sym;
    end else begin : g_rest
      assign prev_sym = list[k-1];
    end
    mtf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (sym_t'(k)),
      .ctrl     (ctrl),
      .prev_sym (prev_sym),
      .sym      (list[k]),
      .hit      (hit[k])
    );
  end

  mtf_reduce u_reduce (
    .clk  (clk),
    .hit  (hit),
    .list (list),
    .pos  (red_pos),
    .sym  (red_sym)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.shift) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      out_data.value_out     <= direction ? red_sym : red_pos;
      out_data.last_of_block <= last_q;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for move_to_front_transform: random items and stalls on both channels.
// Keeps its own copy of the symbol list and checks every result item in order.
// Depends on mtf_pkg and the move_to_front_transform RTL.

module tb;
  import mtf_pkg::*;

  localparam bit DIR_ENCODE = 1'b0;
  localparam bit DIR_DECODE = 1'b1;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 210;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predicted list contents and coding direction
  sym_t mtf_list [LIST_SIZE];
  bit   decode_mode = DIR_ENCODE;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   mismatch_count = 0;

  move_to_front_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Code one item against the predicted list, then move its symbol to the front
  function automatic out_item_t move_to_front_step(in_item_t item);
    out_item_t res;
    int        pos;
    sym_t      sym;
    pos = 0;
    if (decode_mode == DIR_DECODE) begin
      pos = int'(item.value_in);
    end else begin
      for (int k = 0; k < LIST_SIZE; k++) begin
        if (mtf_list[k] == item.value_in) pos = k;
      end
    end
    sym = mtf_list[pos];
    for (int k = pos; k > 0; k--) mtf_list[k] = mtf_list[k-1];
    mtf_list[0] = sym;
    res.value_out = (decode_mode == DIR_DECODE) ? sym : sym_t'(pos);
    res.last_of_block = item.last_in_block;
    return res;
  endfunction

  // Mostly short gaps, a few long ones; none at all in calm mode
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Values skewed toward small numbers (front positions when decoding), as in real MTF traffic
  function automatic sym_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return sym_t'($urandom_range(0, 255));
    if (r < 7) return sym_t'($urandom_range(0, 7));
    if (r < 8) return ($urandom_range(0, 1) != 0) ? sym_t'(255) : sym_t'(0);
    return sym_t'($urandom_range(0, 31));
  endfunction

  task automatic add_item(sym_t v, bit last);
    in_item_t item;
    item.value_in = v;
    item.last_in_block = last;
    pending_items = {pending_items, item};
  endtask

  // Wait until every queued item is sent and every result has come back
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(bit dir);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= dir;
    @(negedge clk);
    cfg_write <= 1'b0;
    decode_mode = dir;
  endtask

  // Drive input items; hold each one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap(out_calm);
    end
  end

  // Predict on each accepted input item, check each accepted result item
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      expected_results = {expected_results, move_to_front_step(in_data)};
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: value_out %0d last_of_block %0d",
               out_data.value_out, out_data.last_of_block);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_data.value_out);
          mismatch_count++;
        end
        if (out_data.last_of_block !== want.last_of_block) begin
          $error("last_of_block: expected %0d, got %0d",
                 want.last_of_block, out_data.last_of_block);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: directed checks, then random phases in both directions
  initial begin
    bit dir;
    for (int k = 0; k < LIST_SIZE; k++) mtf_list[k] = sym_t'(k);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Encode: symbol at front, extremes, repeats, block boundaries
    add_item(8'd0, 1'b0);
    add_item(8'd255, 1'b0);
    add_item(8'd255, 1'b1);
    add_item(8'd0, 1'b0);
    add_item(8'd128, 1'b0);
    add_item(8'd127, 1'b1);
    add_item(8'd1, 1'b0);
    add_item(8'd0, 1'b1);
    drain();

    // Decode continues on the same list
    write_direction(DIR_DECODE);
    add_item(8'd0, 1'b0);
    add_item(8'd255, 1'b0);
    add_item(8'd1, 1'b1);
    add_item(8'd255, 1'b0);
    add_item(8'd128, 1'b1);
    add_item(8'd0, 1'b0);
    add_item(8'd254, 1'b1);
    drain();

    write_direction(DIR_ENCODE);
    add_item(8'd170, 1'b0);
    add_item(8'd85, 1'b0);
    add_item(8'd170, 1'b1);
    add_item(8'd0, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      dir = (p % 3 == 2) ? bit'($urandom_range(0, 1)) : bit'(p % 2 == 0);
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      write_direction(dir);
      for (int i = 0; i < PHASE_ITEMS; i++)
        add_item(pick_value(), $urandom_range(0, 15) == 0);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mtf_pkg.sv
hw/rtl/mtf_cell.sv
hw/rtl/mtf_reduce.sv
hw/rtl/move_to_front_transform.sv
tb/tb.sv
